@@ src/pcmc_pkg.sv @@
// Shared types and constants for the pixel colour model converter.
`timescale 1ns / 1ps
package pcmc_pkg;

	localparam logic [2:0] FN_PREMUL   = 3'd0;
	localparam logic [2:0] FN_UNPREMUL = 3'd1;
	localparam logic [2:0] FN_GRAY     = 3'd2;
	localparam logic [2:0] FN_TO_CMYK  = 3'd3;
	localparam logic [2:0] FN_TO_RGB   = 3'd4;

	// Back-end operation classes
	localparam logic [1:0] MD_CONST = 2'd0;
	localparam logic [1:0] MD_MUL   = 2'd1;
	localparam logic [1:0] MD_DIV   = 2'd2;
	localparam logic [1:0] MD_LUMA  = 2'd3;

	localparam logic [7:0]  CHAN_MAX     = 8'd255;
	// ceil(2^32 / 255): exact floor division by 255 for numerators below 2^24
	localparam logic [24:0] DIV255_RECIP = 25'd16843010;
	localparam logic [23:0] LUMA_R       = 24'd19595;
	localparam logic [23:0] LUMA_G       = 24'd38470;
	localparam logic [23:0] LUMA_B       = 24'd7471;
	localparam logic [32:0] LUMA_EXPAND  = 33'd257;
	localparam logic [32:0] LUMA_ROUND   = 33'd32768;

	localparam int QBITS = 8;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] chan_first;
		logic [7:0] chan_second;
		logic [7:0] chan_third;
		logic [7:0] chan_fourth;
	} in_item_t;

	typedef struct packed {
		logic [7:0] res_first;
		logic [7:0] res_second;
		logic [7:0] res_third;
		logic [7:0] res_fourth;
	} out_item_t;

	typedef struct packed {
		logic [1:0]      mode;
		logic            sub;   // divide: set for cmyk, clear for unpremultiply
		logic [2:0]      sat;
		logic [2:0][7:0] chan;
		logic [7:0]      m;
		logic [7:0]      r3;
	} cls_t;

endpackage

@@ src/pcmc_front.sv @@
// Front end: decodes an incoming pixel into an operation class and operands.
`timescale 1ns / 1ps
module pcmc_front (
	input  pcmc_pkg::in_item_t pixel,
	output pcmc_pkg::cls_t     cls
);
	import pcmc_pkg::*;

	logic [7:0] mx;

	always_comb begin
		mx = pixel.chan_first;
		if (pixel.chan_second > mx) begin
			mx = pixel.chan_second;
		end
		if (pixel.chan_third > mx) begin
			mx = pixel.chan_third;
		end
	end

	always_comb begin
		cls = '0;
		cls.mode = MD_CONST;
		unique case (pixel.func)
			FN_PREMUL: begin
				cls.mode = MD_MUL;
				cls.chan = {pixel.chan_third, pixel.chan_second, pixel.chan_first};
				cls.m    = pixel.chan_fourth;
				cls.r3   = pixel.chan_fourth;
			end
			FN_UNPREMUL: begin
				if (pixel.chan_fourth == CHAN_MAX) begin
					cls.chan = {pixel.chan_third, pixel.chan_second, pixel.chan_first};
					cls.r3   = CHAN_MAX;
				end else if (pixel.chan_fourth != 8'd0) begin
					cls.mode = MD_DIV;
					cls.chan = {pixel.chan_third, pixel.chan_second, pixel.chan_first};
					cls.m    = pixel.chan_fourth;
					cls.r3   = pixel.chan_fourth;
					cls.sat  = {pixel.chan_third > pixel.chan_fourth,
						pixel.chan_second > pixel.chan_fourth,
						pixel.chan_first > pixel.chan_fourth};
				end
			end
			FN_GRAY: begin
				cls.mode = MD_LUMA;
				cls.chan = {pixel.chan_third, pixel.chan_second, pixel.chan_first};
			end
			FN_TO_CMYK: begin
				if (mx == 8'd0) begin
					cls.r3 = CHAN_MAX;
				end else begin
					cls.mode = MD_DIV;
					cls.sub  = 1'b1;
					cls.chan = {mx - pixel.chan_third, mx - pixel.chan_second,
						mx - pixel.chan_first};
					cls.m    = mx;
					cls.r3   = CHAN_MAX - mx;
				end
			end
			FN_TO_RGB: begin
				// (65535 - ink*257) * w / 65535 reduces to (255-ink)*(255-k)*257/255
				cls.mode = MD_MUL;
				cls.chan = {~pixel.chan_third, ~pixel.chan_second, ~pixel.chan_first};
				cls.m    = ~pixel.chan_fourth;
				cls.r3   = CHAN_MAX;
			end
			default: begin
				cls.mode = MD_CONST;
			end
		endcase
	end

endmodule

@@ src/pcmc_queue.sv @@
// Short queue between the front and back ends.
`timescale 1ns / 1ps
module pcmc_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  pcmc_pkg::cls_t wdata,
	output logic           full,
	input  logic           rd,
	output pcmc_pkg::cls_t rdata,
	output logic           vld
);
	import pcmc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign vld   = (cnt_q != '0);
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && vld;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count overflow");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("queue count slip");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wp_q == rp_q)) else $error("queue pointers disagree");

endmodule

@@ src/pcmc_back.sv @@
// Back end: multiply, luma and pipelined divide lanes plus the result register.
`timescale 1ns / 1ps
module pcmc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_vld,
	input  pcmc_pkg::cls_t      q_item,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output pcmc_pkg::out_item_t result
);
	import pcmc_pkg::*;

	logic        adv;

	cls_t        cls_s1;
	logic        vld_s1;
	logic [23:0] v_s1 [3];
	logic [15:0] den_s1;

	cls_t        cls_s2;
	logic        vld_s2;
	logic [23:0] rem_s2 [3];
	logic [7:0]  q_s2 [3];
	logic [15:0] den_s2;

	cls_t        cls_sd [QBITS];
	logic        vld_sd [QBITS];
	logic [23:0] rem_sd [QBITS][3];
	logic [7:0]  q_sd   [QBITS][3];
	logic [15:0] den_sd [QBITS];

	logic        out_vld_q;
	out_item_t   out_q;

	logic [23:0] v_nx [3];
	logic [7:0]  q_nx [3];
	logic [23:0] luma_sum;

	assign adv   = !out_vld_q || pop;
	assign q_pop = adv && q_vld;
	assign empty = !out_vld_q;

	// Stage 1: lane products, division operands, luma dot product
	always_comb begin
		luma_sum = 24'(q_item.chan[0]) * LUMA_R + 24'(q_item.chan[1]) * LUMA_G
			+ 24'(q_item.chan[2]) * LUMA_B;
		for (int i = 0; i < 3; i++) begin
			unique case (q_item.mode)
				MD_MUL: v_nx[i] = 24'({q_item.chan[i], q_item.chan[i]}) * 24'(q_item.m);
				MD_DIV: v_nx[i] = q_item.sub
					? (24'(q_item.chan[i]) << 8) - 24'(q_item.chan[i])
					: (24'(q_item.chan[i]) << 16) - 24'(q_item.chan[i]);
				MD_LUMA: v_nx[i] = (i == 0) ? luma_sum : '0;
				default: v_nx[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1 <= q_item;
			v_s1   <= v_nx;
			den_s1 <= q_item.sub ? {8'd0, q_item.m} : {q_item.m, 8'd0};
		end
	end

	// Stage 2: divide by 255 via reciprocal, luma scaling and rounding
	always_comb begin
		logic [48:0] p;
		logic [32:0] t;
		for (int i = 0; i < 3; i++) begin
			p = 49'(v_s1[i]) * 49'(DIV255_RECIP);
			t = 33'(v_s1[i]) * LUMA_EXPAND + LUMA_ROUND;
			unique case (cls_s1.mode)
				MD_MUL:  q_nx[i] = p[47:40];
				MD_LUMA: q_nx[i] = t[31:24];
				default: q_nx[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s2 <= cls_s1;
			rem_s2 <= v_s1;
			q_s2   <= q_nx;
			den_s2 <= den_s1;
		end
	end

	// Divide stages: one restoring quotient bit per stage, MSB first
	for (genvar j = 0; j < QBITS; j++) begin : g_div
		localparam int B = QBITS - 1 - j;
		cls_t        cls_in;
		logic [23:0] rem_in [3];
		logic [7:0]  q_in   [3];
		logic [15:0] den_in;
		logic [23:0] dsh;

		if (j == 0) begin : g_first
			assign cls_in = cls_s2;
			assign rem_in = rem_s2;
			assign q_in   = q_s2;
			assign den_in = den_s2;
		end else begin : g_next
			assign cls_in = cls_sd[j-1];
			assign rem_in = rem_sd[j-1];
			assign q_in   = q_sd[j-1];
			assign den_in = den_sd[j-1];
		end

		assign dsh = {8'd0, den_in} << B;

		always_ff @(posedge clk) begin
			if (adv) begin
				cls_sd[j] <= cls_in;
				den_sd[j] <= den_in;
				for (int i = 0; i < 3; i++) begin
					if (cls_in.mode == MD_DIV && rem_in[i] >= dsh) begin
						rem_sd[j][i]  <= rem_in[i] - dsh;
						q_sd[j][i]    <= q_in[i] | (8'd1 << B);
					end else begin
						rem_sd[j][i]  <= rem_in[i];
						q_sd[j][i]    <= q_in[i];
					end
				end
			end
		end
	end

	// Result selection into the output register
	always_ff @(posedge clk) begin
		logic [7:0] r [3];
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				unique case (cls_sd[QBITS-1].mode)
					MD_CONST: r[i] = cls_sd[QBITS-1].chan[i];
					MD_DIV:   r[i] = (cls_sd[QBITS-1].sat[i] && !cls_sd[QBITS-1].sub)
						? CHAN_MAX : q_sd[QBITS-1][i];
					default:  r[i] = q_sd[QBITS-1][i];
				endcase
			end
			out_q.res_first  <= r[0];
			out_q.res_second <= r[1];
			out_q.res_third  <= r[2];
			out_q.res_fourth <= cls_sd[QBITS-1].r3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_sd    <= '{default: 1'b0};
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= q_vld;
			vld_s2 <= vld_s1;
			vld_sd[0] <= vld_s2;
			for (int j = 1; j < QBITS; j++) begin
				vld_sd[j] <= vld_sd[j-1];
			end
			out_vld_q <= vld_sd[QBITS-1];
		end
	end

	assign result = out_q;

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_sd[QBITS-1]) |=> out_vld_q) else $error("result lost at output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(vld_s1) && $stable(vld_s2) && $stable(vld_sd[QBITS-1])))
		else $error("pipeline moved while stalled");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (adv && q_vld)) else $error("queue read while stalled");

endmodule

@@ src/pixel_color_model_converter_core.sv @@
// Top level of the pixel colour model converter.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------
//  input    | push / full      | pixel  (func + four 8-bit channels)
//  result   | pop / empty      | result (four 8-bit channels)
//
// One item per cycle sustained while results are popped; each item gives one result.
// With no stall an item passes the queue, two arithmetic stages and eight
// divide stages (one quotient bit each) into the output reg, which then
// holds the result on the ports until it is popped.
// Reset clears the queue pointers and all stage valid bits; payload is not reset.
// A result not popped freezes the whole back-end pipeline; the front queue of
// QUEUE_DEPTH items keeps taking pushes until it fills, then full rises.
`timescale 1ns / 1ps
module pixel_color_model_converter_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  pcmc_pkg::in_item_t  pixel,
	output logic                empty,
	input  logic                pop,
	output pcmc_pkg::out_item_t result
);
	import pcmc_pkg::*;

	cls_t cls;       // classified item from the front end
	cls_t q_item;    // oldest queued item
	logic q_vld;
	logic q_pop;

	pcmc_front u_front (
		.pixel (pixel),
		.cls   (cls)
	);

	// Decouples input acceptance from back-end stalls
	pcmc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (cls),
		.full   (full),
		.rd     (q_pop),
		.rdata  (q_item),
		.vld    (q_vld)
	);

	pcmc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_vld  (q_vld),
		.q_item (q_item),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

@@ sim/pixel_color_model_converter_core_test.sv @@
// Testbench for the pixel colour model converter: random and directed pixels checked against a local predictor.
`timescale 1ns / 1ps
module pixel_color_model_converter_core_test;
	import pcmc_pkg::*;

	localparam int LATENCY    = 12;
	localparam int STALL_LIMIT = 2000;
	localparam int N_RANDOM   = 1650;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	in_item_t pixel = '0;
	out_item_t result;

	in_item_t pending_px[$];
	out_item_t expected_px[$];
	int errors = 0;
	int idle_pct = 27;   // idling rate for both sides; zero during the quiet stretch
	bit hold_push = 1'b0;
	bit stim_done = 1'b0;
	int quiet_cycles = 0;

	pixel_color_model_converter_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pixel(pixel),
		.empty(empty), .pop(pop), .result(result)
	);

	always #5 clk = ~clk;

	// Predicted result for one pixel; 32-bit unsigned arithmetic throughout
	function automatic out_item_t convert_pixel(in_item_t p);
		out_item_t r;
		logic [31:0] c0, c1, c2, c3, mx, w, acc, v;
		logic [31:0] c[3];
		r = '0;
		c0 = p.chan_first; c1 = p.chan_second; c2 = p.chan_third; c3 = p.chan_fourth;
		c[0] = c0; c[1] = c1; c[2] = c2;
		case (p.func)
			FN_PREMUL: begin
				r.res_first  = 8'(((c0 * 257 * c3) / 255) >> 8);
				r.res_second = 8'(((c1 * 257 * c3) / 255) >> 8);
				r.res_third  = 8'(((c2 * 257 * c3) / 255) >> 8);
				r.res_fourth = 8'(c3);
			end
			FN_UNPREMUL: begin
				if (c3 == 255) begin
					r.res_first = 8'(c0); r.res_second = 8'(c1); r.res_third = 8'(c2);
					r.res_fourth = 8'd255;
				end else if (c3 != 0) begin
					for (int i = 0; i < 3; i++) begin
						v = (c[i] * 65535 / c3) >> 8;
						c[i] = (v > 255) ? 255 : v;
					end
					r.res_first = 8'(c[0]); r.res_second = 8'(c[1]); r.res_third = 8'(c[2]);
					r.res_fourth = 8'(c3);
				end
			end
			FN_GRAY: begin
				acc = 19595 * (c0 * 257) + 38470 * (c1 * 257) + 7471 * (c2 * 257) + 32768;
				r.res_first = 8'(acc >> 24);
			end
			FN_TO_CMYK: begin
				mx = c0;
				if (c1 > mx) mx = c1;
				if (c2 > mx) mx = c2;
				if (mx == 0) begin
					r.res_fourth = 8'd255;
				end else begin
					r.res_first  = 8'(((mx - c0) * 255) / mx);
					r.res_second = 8'(((mx - c1) * 255) / mx);
					r.res_third  = 8'(((mx - c2) * 255) / mx);
					r.res_fourth = 8'(255 - mx);
				end
			end
			FN_TO_RGB: begin
				w = 32'hffff - c3 * 257;
				r.res_first  = 8'((((32'hffff - c0 * 257) * w) / 32'hffff) >> 8);
				r.res_second = 8'((((32'hffff - c1 * 257) * w) / 32'hffff) >> 8);
				r.res_third  = 8'((((32'hffff - c2 * 257) * w) / 32'hffff) >> 8);
				r.res_fourth = 8'd255;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic in_item_t make_pixel(logic [2:0] f, logic [7:0] a, logic [7:0] b,
			logic [7:0] c, logic [7:0] d);
		in_item_t p;
		p.func = f; p.chan_first = a; p.chan_second = b; p.chan_third = c; p.chan_fourth = d;
		return p;
	endfunction

	// Mostly valid ops, a few unused codes; channels biased towards the extremes now and then
	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// Driver: a new item goes out only when the previous one was taken (or none was up)
	always @(posedge clk) begin
		if (arst_n) begin
			if (!push || !full) begin
				if (pending_px.size() != 0 && !hold_push &&
						$urandom_range(0, 99) >= idle_pct) begin
					pixel <= pending_px[0];
					expected_px.push_back(convert_pixel(pending_px[0]));
					void'(pending_px.pop_front());
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: check the item taken at this edge, then choose the next pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_px.size() == 0) begin
					$error("result with none expected: %h", result);
					errors++;
				end else begin
					if (result.res_first !== expected_px[0].res_first) begin
						$error("res_first expected %0d actual %0d",
							expected_px[0].res_first, result.res_first);
						errors++;
					end
					if (result.res_second !== expected_px[0].res_second) begin
						$error("res_second expected %0d actual %0d",
							expected_px[0].res_second, result.res_second);
						errors++;
					end
					if (result.res_third !== expected_px[0].res_third) begin
						$error("res_third expected %0d actual %0d",
							expected_px[0].res_third, result.res_third);
						errors++;
					end
					if (result.res_fourth !== expected_px[0].res_fourth) begin
						$error("res_fourth expected %0d actual %0d",
							expected_px[0].res_fourth, result.res_fourth);
						errors++;
					end
					void'(expected_px.pop_front());
				end
			end
			pop <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// Watchdog: cycles with no accepted item on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT && !(stim_done && expected_px.size() == 0)) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		// Directed: extremes and every special case
		pending_px.push_back(make_pixel(FN_PREMUL, 8'd255, 8'd0, 8'd128, 8'd255));
		pending_px.push_back(make_pixel(FN_PREMUL, 8'd255, 8'd255, 8'd255, 8'd0));
		pending_px.push_back(make_pixel(FN_PREMUL, 8'd200, 8'd1, 8'd77, 8'd128));
		pending_px.push_back(make_pixel(FN_UNPREMUL, 8'd10, 8'd20, 8'd30, 8'd0));
		pending_px.push_back(make_pixel(FN_UNPREMUL, 8'd10, 8'd200, 8'd255, 8'd255));
		pending_px.push_back(make_pixel(FN_UNPREMUL, 8'd255, 8'd50, 8'd100, 8'd100));
		pending_px.push_back(make_pixel(FN_UNPREMUL, 8'd1, 8'd0, 8'd1, 8'd1));
		pending_px.push_back(make_pixel(FN_UNPREMUL, 8'd254, 8'd127, 8'd0, 8'd254));
		pending_px.push_back(make_pixel(FN_GRAY, 8'd255, 8'd255, 8'd255, 8'd255));
		pending_px.push_back(make_pixel(FN_GRAY, 8'd0, 8'd0, 8'd0, 8'd77));
		pending_px.push_back(make_pixel(FN_GRAY, 8'd255, 8'd0, 8'd0, 8'd0));
		pending_px.push_back(make_pixel(FN_TO_CMYK, 8'd0, 8'd0, 8'd0, 8'd9));
		pending_px.push_back(make_pixel(FN_TO_CMYK, 8'd255, 8'd255, 8'd255, 8'd0));
		pending_px.push_back(make_pixel(FN_TO_CMYK, 8'd1, 8'd0, 8'd0, 8'd0));
		pending_px.push_back(make_pixel(FN_TO_CMYK, 8'd12, 8'd200, 8'd99, 8'd255));
		pending_px.push_back(make_pixel(FN_TO_RGB, 8'd0, 8'd0, 8'd0, 8'd0));
		pending_px.push_back(make_pixel(FN_TO_RGB, 8'd255, 8'd255, 8'd255, 8'd255));
		pending_px.push_back(make_pixel(FN_TO_RGB, 8'd100, 8'd0, 8'd255, 8'd30));
		pending_px.push_back(make_pixel(3'd5, 8'd255, 8'd255, 8'd255, 8'd255));
		pending_px.push_back(make_pixel(3'd6, 8'd1, 8'd2, 8'd3, 8'd4));
		pending_px.push_back(make_pixel(3'd7, 8'd170, 8'd85, 8'd170, 8'd85));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Let the directed items drain completely before going on
		wait (pending_px.size() == 0);
		@(posedge clk);
		hold_push = 1'b1;
		wait (expected_px.size() == 0);
		hold_push = 1'b0;

		for (int i = 0; i < N_RANDOM; i++)
			pending_px.push_back(make_pixel(($urandom_range(0, 19) == 0) ?
				3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
				rand_chan(), rand_chan(), rand_chan(), rand_chan()));

		// Quiet stretch, then back to random idling
		wait (pending_px.size() < N_RANDOM - 300);
		idle_pct = 0;
		wait (pending_px.size() < N_RANDOM - 600);
		idle_pct = 27;

		// Sender holds off until the pipe has emptied
		wait (pending_px.size() < N_RANDOM / 2 - 200);
		hold_push = 1'b1;
		wait (expected_px.size() == 0);
		hold_push = 1'b0;

		wait (pending_px.size() == 0);
		@(posedge clk);
		@(posedge clk);
		stim_done = 1'b1;
		wait (expected_px.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
		if (errors == 0 && expected_px.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

@@ files.f @@
src/pcmc_pkg.sv
src/pcmc_front.sv
src/pcmc_queue.sv
src/pcmc_back.sv
src/pixel_color_model_converter_core.sv
sim/pixel_color_model_converter_core_test.sv
